FILE: sv/jsu_pkg.sv
package jsu_pkg;

	localparam int unsigned CAP_W   = 9;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned RES_SLOTS = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_OUTPUT = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd24;
	localparam logic [CAP_W-1:0] CAP_MAX   = 9'd256;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_N  = 8'h6E;
	localparam logic [7:0] CH_LO_R  = 8'h72;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_FF    = 8'h0C;

	// utf-8 encoding
	localparam logic [15:0] CP_1B_LIM    = 16'h0080;
	localparam logic [15:0] CP_2B_LIM    = 16'h0800;
	localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
	localparam logic [7:0]  UTF8_CONT    = 8'h80;

	typedef enum logic [2:0] {
		PH_SEEK = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX0 = 3'd3,
		PH_HEX1 = 3'd4,
		PH_HEX2 = 3'd5,
		PH_HEX3 = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [7:0] length;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [CAP_W-1:0] out_capacity;
		logic             discard_output;
	} cfg_t;

	// bit 4 set marks a byte that is not a hex digit
	function automatic logic [4:0] hexval(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = 5'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = 5'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = 5'(b - 8'h37);
		end else begin
			v = 5'd16;
		end
		return v;
	endfunction

endpackage

FILE: sv/jsu_if.sv
interface jsu_in_if;
	import jsu_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
	import jsu_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [7:0] length;
	logic       last;
	modport source(output valid, output out_byte, output kind, output length, output last,
		input ready);
	modport sink(input valid, input out_byte, input kind, input length, input last,
		output ready);
endinterface

FILE: sv/jsu_decode.sv
module jsu_decode
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] byte_s1,
	input  cfg_t       cfg,
	output result_t    res [RES_SLOTS],
	output logic [1:0] n_res
);

	phase_t      phase_q, phase_d;
	logic [11:0] acc_q, acc_d;
	logic [7:0]  wc_q, wc_d;

	logic [CAP_W-1:0] cap_eff;
	logic             lt1, lt2, lt3;
	logic [4:0]       hx;
	logic [15:0]      cp;
	logic [7:0]       esc_byte;
	logic             is_ws;

	logic [2:0]       em;
	logic [7:0]       bb [RES_SLOTS];
	logic             fin_en;
	logic [1:0]       fin_kind;
	logic             fin_zero_len;

	assign cap_eff = (cfg.out_capacity > CAP_MAX) ? CAP_MAX : cfg.out_capacity;
	// room for one, two or three more bytes keeping the count below capacity, unless output is discarded
	assign lt1 = !cfg.discard_output && (({1'b0, wc_q} + 9'd1) < cap_eff);
	assign lt2 = !cfg.discard_output && (({1'b0, wc_q} + 9'd2) < cap_eff);
	assign lt3 = !cfg.discard_output && (({1'b0, wc_q} + 9'd3) < cap_eff);

	assign hx = hexval(byte_s1);
	assign cp = {acc_q, hx[3:0]};
	assign is_ws = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) ||
		(byte_s1 == CH_LF) || (byte_s1 == CH_CR);

	always_comb begin
		unique case (byte_s1)
			CH_LO_B: esc_byte = CH_BS;
			CH_LO_F: esc_byte = CH_FF;
			CH_LO_N: esc_byte = CH_LF;
			CH_LO_R: esc_byte = CH_CR;
			CH_LO_T: esc_byte = CH_TAB;
			default: esc_byte = byte_s1;
		endcase
	end

	// which bytes go out and whether this byte ends the string
	always_comb begin
		em           = '0;
		bb           = '{default: '0};
		fin_en       = 1'b0;
		fin_kind     = KIND_ERR;
		fin_zero_len = 1'b0;
		unique case (phase_q)
			PH_SEEK: begin
				if (!is_ws && byte_s1 != CH_QUOTE) begin
					fin_en       = 1'b1;
					fin_zero_len = 1'b1;
				end
			end
			PH_STR: begin
				if (byte_s1 == CH_NUL) begin
					fin_en = 1'b1;
				end else if (byte_s1 == CH_QUOTE) begin
					fin_en   = 1'b1;
					fin_kind = KIND_DONE;
				end else if (byte_s1 != CH_BSL) begin
					bb[0] = byte_s1;
					em[0] = lt1;
				end
			end
			PH_ESC: begin
				if (byte_s1 == CH_NUL) begin
					fin_en = 1'b1;
				end else if (byte_s1 != CH_LO_U) begin
					bb[0] = esc_byte;
					em[0] = lt1;
				end
			end
			PH_HEX0, PH_HEX1, PH_HEX2: begin
				fin_en = hx[4];
			end
			PH_HEX3: begin
				if (hx[4]) begin
					fin_en = 1'b1;
				end else if (cp < CP_1B_LIM) begin
					bb[0] = cp[7:0];
					em[0] = lt1;
				end else if (cp < CP_2B_LIM) begin
					bb[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
					bb[1] = UTF8_CONT | {2'd0, cp[5:0]};
					em[0] = lt1;
					em[1] = lt2;
				end else begin
					// leading pair needs room for two, the tail is checked after it
					bb[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
					bb[1] = UTF8_CONT | {2'd0, cp[11:6]};
					bb[2] = UTF8_CONT | {2'd0, cp[5:0]};
					em[0] = lt2;
					em[1] = lt2;
					em[2] = lt2 ? lt3 : lt1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		wc_d    = wc_q + {7'd0, em[0]} + {7'd0, em[1]} + {7'd0, em[2]};
		if (fin_en) begin
			phase_d = PH_SEEK;
			acc_d   = '0;
			wc_d    = '0;
		end else begin
			unique case (phase_q)
				PH_SEEK: begin
					if (byte_s1 == CH_QUOTE) begin
						phase_d = PH_STR;
						acc_d   = '0;
						wc_d    = '0;
					end
				end
				PH_STR: begin
					if (byte_s1 == CH_BSL) begin
						phase_d = PH_ESC;
					end
				end
				PH_ESC: begin
					if (byte_s1 == CH_LO_U) begin
						phase_d = PH_HEX0;
						acc_d   = '0;
					end else begin
						phase_d = PH_STR;
					end
				end
				PH_HEX0, PH_HEX1, PH_HEX2: begin
					acc_d   = {acc_q[7:0], hx[3:0]};
					phase_d = phase_t'(phase_q + 3'd1);
				end
				PH_HEX3: begin
					phase_d = PH_STR;
					acc_d   = '0;
				end
				default: begin
					phase_d = PH_SEEK;
					acc_d   = '0;
					wc_d    = '0;
				end
			endcase
		end
	end

	// pack the emitted results in order, last flag on the final one
	always_comb begin
		logic [7:0] w;
		logic [1:0] n;
		res = '{default: '0};
		n   = '0;
		w   = wc_q;
		for (int i = 0; i < RES_SLOTS; i++) begin
			if (em[i]) begin
				w      = w + 8'd1;
				res[n] = '{out_byte: bb[i], kind: KIND_DATA, length: w, last: 1'b0};
				n      = n + 2'd1;
			end
		end
		if (fin_en) begin
			res[n] = '{out_byte: 8'd0, kind: fin_kind,
				length: (fin_zero_len ? 8'd0 : wc_q), last: 1'b0};
			n      = n + 2'd1;
		end
		if (n != 2'd0) begin
			res[n - 2'd1].last = 1'b1;
		end
		n_res = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			acc_q   <= '0;
			wc_q    <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			wc_q    <= wc_d;
		end
	end

endmodule

FILE: sv/jsu_rbuf.sv
module jsu_rbuf
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res [RES_SLOTS],
	input  logic [1:0] n_res,
	output logic       can_load,
	jsu_out_if.source  tx
);

	logic [1:0] cnt_q;
	result_t    q_q [RES_SLOTS];
	logic       pop;

	assign pop      = tx.valid && tx.ready;
	// a new group fits once the buffer is empty or drains its last word now
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	assign tx.valid    = (cnt_q != 2'd0);
	assign tx.out_byte = q_q[0].out_byte;
	assign tx.kind     = q_q[0].kind;
	assign tx.length   = q_q[0].length;
	assign tx.last     = q_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= res;
		end else if (pop) begin
			q_q[0] <= q_q[1];
			q_q[1] <= q_q[2];
		end
	end

endmodule

FILE: sv/json_string_unescape_utf8.sv
// channel  dir  payload                          handshake
// rx       in   in_byte[7:0]                     rx.valid / rx.ready
// tx       out  out_byte[7:0] kind[1:0]          tx.valid / tx.ready
//               length[7:0] last
// cfg      in   cfg_index, cfg_wdata[8:0]        cfg_we, no back-pressure
//
// a byte is held in the input register, then decoded into zero to three result
// words that land in a three-word output buffer
// a new byte is taken every cycle while each byte yields at most one word and tx
// is ready; a byte with more words holds the input as the single tx sends them
// reset returns to seeking the opening quote, capacity 24, output not discarded
// a stalled tx holds the buffer head; the input register keeps its byte until the
// buffer can take its words
module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	jsu_in_if.sink               rx,
	jsu_out_if.source            tx,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_wdata
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       process;
	result_t    res [RES_SLOTS];
	logic [1:0] n_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_capacity   <= CAP_RESET;
			cfg_q.discard_output <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OUT_CAPACITY:   cfg_q.out_capacity   <= cfg_wdata;
				CFG_DISCARD_OUTPUT: cfg_q.discard_output <= cfg_wdata[0];
			endcase
		end
	end

	assign process  = valid_s1 && can_load;
	assign rx.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.in_byte;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (process),
		.byte_s1 (byte_s1),
		.cfg     (cfg_q),
		.res     (res),
		.n_res   (n_res)
	);

	jsu_rbuf u_rbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (process),
		.res      (res),
		.n_res    (n_res),
		.can_load (can_load),
		.tx       (tx)
	);

	// a completion or error word always closes its byte's group
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.kind != KIND_DATA |-> tx.last)
		else $error("end word without last flag");

	// a data word always counts itself
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.kind == KIND_DATA |-> tx.length != 8'd0)
		else $error("data word with zero length");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.kind == KIND_DATA || tx.kind == KIND_DONE || tx.kind == KIND_ERR))
		else $error("undefined result kind");

	// a byte waiting on a full buffer is not overwritten
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !can_load |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a pending byte");

endmodule

FILE: test/tb.sv
module tb;
	import jsu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 160;
	localparam int DRAIN_CYCLES = 8;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX   = 50;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0] cfg_wdata;

	jsu_in_if rx_if();
	jsu_out_if tx_if();

	json_string_unescape_utf8 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.tx        (tx_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder shadow state and register copies
	phase_t     ph = PH_SEEK;
	logic [11:0] cp_acc = '0;
	logic [7:0] wcount = '0;
	logic [CAP_W-1:0] cap = CAP_RESET;
	logic       dsc = 1'b0;

	result_t    step_words[3];
	int         step_n;
	result_t    unescaped_q[$];
	logic [7:0] stim_q[$];

	int  mismatch_cnt = 0;
	int  sent_cnt = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	bit  idle_on = 1'b1;
	bit  stall_on = 1'b1;

	task automatic report(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX) begin
			$display("mismatch at %0t ns: %s", $time, what);
		end
	endtask

	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic int cap_limit();
		return (cap > CAP_MAX) ? int'(CAP_MAX) : int'(cap);
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic [1:0] k,
			input logic [7:0] len);
		result_t w;
		w.out_byte = b;
		w.kind = k;
		w.length = len;
		w.last = 1'b0;
		step_words[step_n] = w;
		step_n++;
	endfunction

	function automatic void emit_data(input logic [7:0] b);
		if (!dsc && int'(wcount) + 1 < cap_limit()) begin
			wcount++;
			push_word(b, KIND_DATA, wcount);
		end
	endfunction

	function automatic void close_string(input logic [1:0] k);
		push_word(8'h00, k, (k == KIND_ERR && ph == PH_SEEK) ? 8'd0 : wcount);
		ph = PH_SEEK;
		wcount = '0;
		cp_acc = '0;
	endfunction

	// works out the words one accepted byte produces and queues them
	function automatic void unescape_byte(input logic [7:0] b);
		int d;
		logic [15:0] cp;
		result_t w;
		step_n = 0;
		case (ph)
			PH_SEEK: begin
				if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
				end else if (b == CH_QUOTE) begin
					ph = PH_STR;
					wcount = '0;
					cp_acc = '0;
				end else begin
					close_string(KIND_ERR);
				end
			end
			PH_STR: begin
				if (b == CH_NUL) close_string(KIND_ERR);
				else if (b == CH_QUOTE) close_string(KIND_DONE);
				else if (b == CH_BSL) ph = PH_ESC;
				else emit_data(b);
			end
			PH_ESC: begin
				ph = PH_STR;
				if (b == CH_NUL) begin
					close_string(KIND_ERR);
				end else if (b == CH_LO_U) begin
					ph = PH_HEX0;
					cp_acc = '0;
				end else if (b == CH_LO_B) begin
					emit_data(CH_BS);
				end else if (b == CH_LO_F) begin
					emit_data(CH_FF);
				end else if (b == CH_LO_N) begin
					emit_data(CH_LF);
				end else if (b == CH_LO_R) begin
					emit_data(CH_CR);
				end else if (b == CH_LO_T) begin
					emit_data(CH_TAB);
				end else begin
					emit_data(b);
				end
			end
			PH_HEX0, PH_HEX1, PH_HEX2: begin
				d = hex_value(b);
				if (d < 0) begin
					close_string(KIND_ERR);
				end else begin
					cp_acc = {cp_acc[7:0], 4'(d)};
					ph = phase_t'(ph + 1);
				end
			end
			PH_HEX3: begin
				d = hex_value(b);
				if (d < 0) begin
					close_string(KIND_ERR);
				end else begin
					cp = {cp_acc, 4'(d)};
					ph = PH_STR;
					cp_acc = '0;
					if (cp < CP_1B_LIM) begin
						emit_data(cp[7:0]);
					end else if (cp < CP_2B_LIM) begin
						emit_data(UTF8_LEAD2 | {3'b000, cp[10:6]});
						emit_data(UTF8_CONT | {2'b00, cp[5:0]});
					end else begin
						// lead and middle bytes need room for two together
						if (!dsc && int'(wcount) + 2 < cap_limit()) begin
							wcount++;
							push_word(UTF8_LEAD3 | {4'h0, cp[15:12]}, KIND_DATA, wcount);
							wcount++;
							push_word(UTF8_CONT | {2'b00, cp[11:6]}, KIND_DATA, wcount);
						end
						emit_data(UTF8_CONT | {2'b00, cp[5:0]});
					end
				end
			end
			default: begin
				ph = PH_SEEK;
				wcount = '0;
				cp_acc = '0;
			end
		endcase
		for (int i = 0; i < step_n; i++) begin
			w = step_words[i];
			w.last = (i == step_n - 1);
			unescaped_q.push_back(w);
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (tx_if.valid && tx_if.ready) begin
				if (unescaped_q.size() == 0) begin
					report($sformatf("word byte %02h kind %0d length %0d with nothing pending",
						tx_if.out_byte, tx_if.kind, tx_if.length));
				end else begin
					want = unescaped_q.pop_front();
					if (tx_if.out_byte !== want.out_byte)
						report($sformatf("out_byte %02h, want %02h", tx_if.out_byte,
							want.out_byte));
					if (tx_if.kind !== want.kind)
						report($sformatf("kind %0d, want %0d", tx_if.kind, want.kind));
					if (tx_if.length !== want.length)
						report($sformatf("length %0d, want %0d", tx_if.length, want.length));
					if (tx_if.last !== want.last)
						report($sformatf("last %0b, want %0b", tx_if.last, want.last));
				end
			end
			if (rx_if.valid && rx_if.ready) unescape_byte(rx_if.in_byte);
		end
	end

	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("** json_string_unescape_utf8: FAILED **");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			tx_if.ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			tx_if.ready <= 1'b0;
		end else begin
			tx_if.ready <= 1'b1;
		end
	end

	task automatic send_stim();
		logic [7:0] b;
		while (stim_q.size() != 0) begin
			b = stim_q.pop_front();
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				rx_if.valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			rx_if.valid <= 1'b1;
			rx_if.in_byte <= b;
			do @(posedge clk); while (!rx_if.ready);
			sent_cnt++;
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (unescaped_q.size() != 0) @(posedge clk);
		// a byte that yields no word may still sit in the input register
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == CFG_OUT_CAPACITY) cap = val;
		else if (idx == CFG_DISCARD_OUTPUT) dsc = val[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 10) return "0" + nib;
		return (upper ? "A" : "a") + nib - 8'd10;
	endfunction

	function automatic void add_unicode(input logic [15:0] cp);
		stim_q.push_back(CH_BSL);
		stim_q.push_back(CH_LO_U);
		for (int i = 3; i >= 0; i--)
			stim_q.push_back(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
	endfunction

	function automatic void add_plain();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
		stim_q.push_back(b);
	endfunction

	// a string with random content, mostly well formed, sometimes cut short
	function automatic void add_string();
		logic [7:0] b;
		logic [7:0] ws[4];
		logic [7:0] esc[8];
		int ending;
		ws = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
		esc = '{CH_QUOTE, CH_BSL, "/", CH_LO_B, CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T};
		repeat ($urandom_range(0, 2)) stim_q.push_back(ws[$urandom_range(0, 3)]);
		stim_q.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: add_plain();
				4, 5: begin
					stim_q.push_back(CH_BSL);
					stim_q.push_back(esc[$urandom_range(0, 7)]);
				end
				6: begin
					stim_q.push_back(CH_BSL);
					do b = 8'($urandom_range(1, 255)); while (b == CH_LO_U);
					stim_q.push_back(b);
				end
				7: add_unicode(16'($urandom_range(0, 16'h7F)));
				8: add_unicode(16'($urandom_range(16'h80, 16'h7FF)));
				default: add_unicode(16'($urandom_range(16'h800, 16'hFFFF)));
			endcase
		end
		ending = $urandom_range(0, 11);
		if (ending == 0) begin
			stim_q.push_back(CH_NUL);
		end else if (ending == 1) begin
			stim_q.push_back(CH_BSL);
			stim_q.push_back(CH_NUL);
		end else if (ending == 2) begin
			// bad hex digit somewhere inside a \u escape
			stim_q.push_back(CH_BSL);
			stim_q.push_back(CH_LO_U);
			repeat ($urandom_range(0, 3)) stim_q.push_back(hex_char(4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1))));
			do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
			stim_q.push_back(b);
		end else begin
			stim_q.push_back(CH_QUOTE);
		end
	endfunction

	task automatic test_directed();
		stim_q = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_QUOTE, 8'hFF, 8'h01,
			CH_BSL, CH_LO_N, CH_BSL, "q",
			CH_BSL, CH_LO_U, "0", "0", "0", "0",
			CH_BSL, CH_LO_U, "0", "7", "f", "F",
			CH_BSL, CH_LO_U, "F", "f", "a", "0", CH_QUOTE,
			CH_NUL,
			CH_QUOTE, "a", CH_BSL, CH_LO_U, "1", "g"};
		send_stim();
	endtask

	task automatic test_capacity();
		for (int c = 0; c <= 5; c++) begin
			wait_drain();
			write_reg(CFG_OUT_CAPACITY, CAP_W'(c));
			stim_q.push_back(CH_QUOTE);
			stim_q.push_back("a");
			add_unicode(16'h20AC);
			add_unicode(16'h00E9);
			stim_q.push_back("b");
			stim_q.push_back(CH_QUOTE);
			send_stim();
		end
	endtask

	task automatic test_discard();
		wait_drain();
		write_reg(CFG_OUT_CAPACITY, CAP_RESET);
		write_reg(CFG_DISCARD_OUTPUT, CAP_W'(1));
		stim_q = '{CH_QUOTE, "a", "b", CH_BSL, CH_LO_N, CH_QUOTE, CH_QUOTE, "x", CH_NUL};
		add_unicode(16'h20AC);
		send_stim();
		wait_drain();
		write_reg(CFG_DISCARD_OUTPUT, '0);
	endtask

	task automatic test_random();
		int start;
		logic [CAP_W-1:0] c;
		logic [7:0] junk;
		bit quiet_part;
		start = sent_cnt;
		while (sent_cnt - start < RANDOM_ITEMS) begin
			wait_drain();
			case ($urandom_range(0, 9))
				0: c = CAP_W'($urandom_range(0, 4));
				1: c = $urandom_range(0, 1) ? CAP_MAX : CAP_W'($urandom_range(257, 511));
				default: c = CAP_W'($urandom_range(5, 40));
			endcase
			write_reg(CFG_OUT_CAPACITY, c);
			write_reg(CFG_DISCARD_OUTPUT, CAP_W'($urandom_range(0, 4) == 0));
			quiet_part = (sent_cnt - start) > RANDOM_ITEMS * 4 / 5;
			idle_on = !quiet_part && ($urandom_range(0, 3) != 0);
			stall_on = !quiet_part && ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 7) == 0) begin
					// stray byte before the opening quote
					do junk = 8'($urandom_range(0, 255));
					while (junk == CH_SPACE || junk == CH_TAB || junk == CH_LF ||
						junk == CH_CR || junk == CH_QUOTE);
					stim_q.push_back(junk);
				end
				add_string();
				send_stim();
				if ($urandom_range(0, 9) == 0) wait_drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.in_byte = 8'h00;
		tx_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_capacity();
		test_discard();
		test_random();

		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (unescaped_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && unescaped_q.size() == 0) begin
			$display("** json_string_unescape_utf8: PASSED **");
		end else begin
			$display("** json_string_unescape_utf8: FAILED **");
		end
		$finish;
	end

endmodule
